// ----- src/fixed_block_free_list_allocator_defines.svh -----
// ---------------------------------------------------------------------------
// fixed_block_free_list_allocator_defines.svh
// Assertion macros for the free-list allocator. Each macro expects clk and
// rst in scope.
// ---------------------------------------------------------------------------
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_DEFINES_SVH

// Same-cycle implication.
`define FBFL_ASSERT_HOLD(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FBFL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/fbfl_pkg.sv -----
// ---------------------------------------------------------------------------
// fbfl_pkg
// Codes and field widths for the fixed-block free-list allocator.
// ---------------------------------------------------------------------------
package fbfl_pkg;

  localparam int COUNT_W  = 9;
  localparam int BYTES_W  = 13;
  localparam int INDEX_W  = 8;
  localparam int OFFSET_W = 20;

  typedef logic [1:0]          status_t;
  typedef logic [0:0]          op_t;
  typedef logic [0:0]          cfg_index_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [BYTES_W-1:0]  bytes_t;
  typedef logic [INDEX_W-1:0]  index_t;
  typedef logic [OFFSET_W-1:0] offset_t;

  localparam status_t STATUS_OK    = 2'd0;
  localparam status_t STATUS_EMPTY = 2'd1;
  localparam status_t STATUS_RANGE = 2'd2;

  localparam op_t OP_ALLOC = 1'b0;
  localparam op_t OP_FREE  = 1'b1;

  localparam cfg_index_t CFG_BLOCK_COUNT = 1'b0;
  localparam cfg_index_t CFG_BLOCK_BYTES = 1'b1;

  localparam count_t RESET_COUNT_MAX = 9'd256;
  localparam bytes_t RESET_BYTES     = 13'd8;

endpackage

// ----- src/fixed_block_free_list_allocator.sv -----
// Allocate: one link memory read of the head, then the result is formed in the ALLOC state.
// Free, out-of-range free and allocate from an empty pool: the result is formed as the request is accepted.
// One request is in work at a time; a finished result waits in the output
// register while the next request is taken. After reset and after a block_count
// write the chain is rebuilt, one link per cycle, over block_count links (256 by default).
// ---------------------------------------------------------------------------
// fixed_block_free_list_allocator
// Fixed-size block pool kept as a linked free list in a link memory, with a
// free counter, aligned byte offsets and a range check on frees.
// ---------------------------------------------------------------------------
`include "fixed_block_free_list_allocator_defines.svh"

module fixed_block_free_list_allocator #(
  parameter int MAX_BLOCKS  = 256,
  parameter int ALIGN_BYTES = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  fbfl_pkg::cfg_index_t cfg_index,
  input  fbfl_pkg::bytes_t     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  fbfl_pkg::op_t        op,
  input  fbfl_pkg::index_t     block_index,
  output logic                 out_valid,
  input  logic                 out_stall,
  output fbfl_pkg::status_t    status,
  output fbfl_pkg::index_t     granted_index,
  output fbfl_pkg::offset_t    byte_offset,
  output fbfl_pkg::count_t     free_count
);
  import fbfl_pkg::*;

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = ((IW > COUNT_W) ? IW : COUNT_W) + 1;
  // Rounded size stays below 2*8192, so one extra bit covers any alignment up to 8193.
  localparam int XW = BYTES_W + 1;
  localparam int MW = 21;
  localparam int RECIP_SHIFT = 20;
  localparam logic [MW-1:0] ALIGN_RECIP = MW'((1 << RECIP_SHIFT) / ALIGN_BYTES);
  localparam int QW = XW + 7;
  localparam int OW = (IW + XW > OFFSET_W) ? IW + XW : OFFSET_W;
  localparam count_t RESET_COUNT = (MAX_BLOCKS > 256) ? RESET_COUNT_MAX
                                                      : COUNT_W'(MAX_BLOCKS);
  localparam count_t COUNT_CLAMP = (MAX_BLOCKS > 511) ? 9'd511 : COUNT_W'(MAX_BLOCKS);

  localparam logic [1:0] ST_SWEEP  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_ALLOC  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]       state;
  count_t           block_count;
  bytes_t           block_bytes;
  logic [1:0]       settle;
  logic [XW+MW-1:0] mult_prod;
  logic [XW-1:0]    aligned;
  logic             head_end;
  logic [IW-1:0]    head_idx;
  count_t           free_counter;
  logic [IW-1:0]    sweep_idx;
  logic [IW:0]      link_mem [MAX_BLOCKS];
  logic [IW:0]      rdata;

  status_t          pend_status;
  index_t           pend_index;
  offset_t          pend_offset;
  count_t           pend_count;

  logic             accept;
  logic             slot_free;
  logic             idx_ok;
  count_t           cnt_inc;
  count_t           cnt_dec;
  logic [CW-1:0]    head_ext;
  logic [OW-1:0]    off_prod;
  logic [CW-1:0]    sweep_next;
  logic             sweep_last;
  logic [IW:0]      sweep_link;
  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  logic [IW:0]      wr_data;
  logic             rd_en;
  logic [XW-1:0]    round_x;
  logic [XW-1:0]    q0;
  logic [QW-1:0]    qa_full;
  logic [XW-1:0]    qa;
  logic [XW-1:0]    rem;
  count_t           count_wr;

  logic             res_ready;
  status_t          res_status;
  index_t           res_index;
  offset_t          res_offset;
  count_t           res_count;

  assign in_stall  = (state != ST_IDLE) || (settle != 2'd0);
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;
  assign idx_ok    = ({1'b0, block_index} < block_count);
  assign cnt_inc   = (free_counter < block_count) ? free_counter + 9'd1 : free_counter;
  assign cnt_dec   = (free_counter != '0) ? free_counter - 9'd1 : free_counter;
  assign head_ext  = CW'(head_idx);
  assign off_prod  = OW'(head_idx) * OW'(aligned);

  assign sweep_next = CW'(sweep_idx) + CW'(1);
  assign sweep_last = (sweep_next >= CW'(block_count));
  assign sweep_link = sweep_last ? {1'b1, IW'(0)} : {1'b0, sweep_next[IW-1:0]};

  assign wr_en   = (state == ST_SWEEP) ||
                   ((state == ST_IDLE) && accept && (op == OP_FREE) && idx_ok);
  assign wr_addr = (state == ST_SWEEP) ? sweep_idx : IW'(block_index);
  assign wr_data = (state == ST_SWEEP) ? sweep_link : {head_end, head_idx};
  assign rd_en   = (state == ST_IDLE) && accept && (op == OP_ALLOC) && !head_end;

  // Round block_bytes up to the alignment: reciprocal estimate, then correct.
  assign round_x = XW'(block_bytes) + XW'(ALIGN_BYTES - 1);
  assign q0      = mult_prod[RECIP_SHIFT +: XW];
  assign qa_full = QW'(q0) * QW'(ALIGN_BYTES);
  assign qa      = qa_full[XW-1:0];
  assign rem     = round_x - qa;

  always_comb begin
    count_wr = cfg_data[COUNT_W-1:0];
    if (count_wr == '0) begin
      count_wr = 9'd1;
    end else if (CW'(count_wr) > CW'(COUNT_CLAMP)) begin
      count_wr = COUNT_CLAMP;
    end
  end

  always_comb begin
    res_ready  = 1'b0;
    res_status = STATUS_OK;
    res_index  = '0;
    res_offset = '0;
    res_count  = free_counter;
    if ((state == ST_IDLE) && accept) begin
      if (op == OP_FREE) begin
        res_ready  = 1'b1;
        res_status = idx_ok ? STATUS_OK : STATUS_RANGE;
        res_count  = idx_ok ? cnt_inc : free_counter;
      end else if (head_end) begin
        res_ready  = 1'b1;
        res_status = STATUS_EMPTY;
      end
    end else if (state == ST_ALLOC) begin
      res_ready  = 1'b1;
      res_index  = pend_index;
      res_offset = pend_offset;
      res_count  = cnt_dec;
    end
  end

  // Link memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      link_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= link_mem[head_idx];
    end
  end

  always_ff @(posedge clk) begin
    mult_prod <= (XW + MW)'(round_x) * (XW + MW)'(ALIGN_RECIP);
    aligned   <= (rem >= XW'(ALIGN_BYTES)) ? qa + XW'(ALIGN_BYTES) : qa;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_SWEEP;
      sweep_idx    <= '0;
      block_count  <= RESET_COUNT;
      block_bytes  <= RESET_BYTES;
      settle       <= 2'd2;
      out_valid    <= 1'b0;
      head_end     <= 1'b1;
      head_idx     <= '0;
      free_counter <= '0;
    end else begin
      if (settle != 2'd0) begin
        settle <= settle - 2'd1;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_SWEEP: begin
          if (sweep_last) begin
            state        <= ST_IDLE;
            head_end     <= 1'b0;
            head_idx     <= '0;
            free_counter <= block_count;
          end else begin
            sweep_idx <= sweep_next[IW-1:0];
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (op == OP_FREE) begin
              if (idx_ok) begin
                head_idx     <= IW'(block_index);
                head_end     <= 1'b0;
                free_counter <= cnt_inc;
              end
            end else if (!head_end) begin
              state <= ST_ALLOC;
            end
          end
        end
        ST_ALLOC: begin
          // Advance the head to the popped block's link.
          head_end     <= rdata[IW];
          head_idx     <= rdata[IW-1:0];
          free_counter <= cnt_dec;
          state        <= ST_IDLE;
        end
        ST_FINISH: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (res_ready) begin
        if (slot_free) begin
          out_valid <= 1'b1;
        end else begin
          // Hold the result until the output register drains.
          state <= ST_FINISH;
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          CFG_BLOCK_COUNT: begin
            block_count <= count_wr;
            sweep_idx   <= '0;
            state       <= ST_SWEEP;
          end
          CFG_BLOCK_BYTES: begin
            block_bytes <= cfg_data;
            settle      <= 2'd2;
          end
          default: begin
            block_bytes <= block_bytes;
          end
        endcase
      end
    end
  end

  // Result payload: no reset needed.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      pend_index  <= head_ext[INDEX_W-1:0];
      pend_offset <= off_prod[OFFSET_W-1:0];
    end
    if (res_ready && !slot_free) begin
      pend_status <= res_status;
      pend_index  <= res_index;
      pend_offset <= res_offset;
      pend_count  <= res_count;
    end
    if (res_ready && slot_free) begin
      status        <= res_status;
      granted_index <= res_index;
      byte_offset   <= res_offset;
      free_count    <= res_count;
    end else if ((state == ST_FINISH) && slot_free) begin
      status        <= pend_status;
      granted_index <= pend_index;
      byte_offset   <= pend_offset;
      free_count    <= pend_count;
    end
  end

  `FBFL_ASSERT_HOLD(a_empty_count, (state != ST_SWEEP) && head_end, free_counter == '0, "free count nonzero with empty list")
  `FBFL_ASSERT_HOLD(a_count_bound, (state != ST_SWEEP), free_counter <= block_count, "free count above block count")
  `FBFL_ASSERT_HOLD(a_sweep_range, (state == ST_SWEEP), CW'(sweep_idx) < CW'(block_count), "rebuild index past block count")
  `FBFL_ASSERT_NEXT(a_alloc_read, rd_en && !cfg_write, state == ST_ALLOC, "allocate did not wait for link read")
  `FBFL_ASSERT_NEXT(a_result_out, res_ready && slot_free, out_valid, "finished result not presented")

endmodule

// ----- test/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the fixed-block free-list allocator. A scoreboard
// class tracks its own copy of the free chain, counter and registers, predicts
// each result when a request is accepted and compares results in order.
// Directed requests cover the corner cases. Random phases then reconfigure the
// pool and run alloc/free traffic with random gaps, stalls and one long hold.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fbfl_pkg::*;

  localparam int POOL_MAX    = 256;
  localparam int ALIGN       = 8;
  localparam int LONG_HOLD   = 150;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    status_t status;
    index_t  granted;
    offset_t offset;
    count_t  count;
  } alloc_result_t;

  class pool_scoreboard;
    count_t        pool_size;
    bytes_t        unit_bytes;
    logic [8:0]    head;            // bit 8 set: chain is empty
    logic [8:0]    links[POOL_MAX];
    count_t        free_blocks;
    alloc_result_t due[$];
    int            errors;

    function new();
      pool_size  = RESET_COUNT_MAX;
      unit_bytes = RESET_BYTES;
      errors     = 0;
      rechain();
    endfunction

    function void rechain();
      for (int i = 0; i < POOL_MAX; i++)
        links[i] = (i + 1 < pool_size) ? 9'(i + 1) : 9'h100;
      head        = 9'd0;
      free_blocks = pool_size;
    endfunction

    function void configure(cfg_index_t r, bytes_t v);
      count_t c;
      case (r)
        CFG_BLOCK_COUNT: begin
          c = v[COUNT_W-1:0];
          if (c == 0) c = 9'd1;
          if (c > POOL_MAX) c = count_t'(POOL_MAX);
          pool_size = c;
          rechain();
        end
        CFG_BLOCK_BYTES: unit_bytes = v;
        default: ;
      endcase
    endfunction

    function alloc_result_t note_request(op_t o, index_t i);
      alloc_result_t r;
      int unsigned   aligned;
      r = '0;
      if (o == OP_ALLOC) begin
        if (head[8]) begin
          r.status = STATUS_EMPTY;
        end else begin
          r.status  = STATUS_OK;
          r.granted = head[7:0];
          aligned   = (int'(unit_bytes) + ALIGN - 1) / ALIGN * ALIGN;
          r.offset  = offset_t'(int'(head[7:0]) * aligned);
          head      = links[head[7:0]];
          if (free_blocks > 0) free_blocks--;
        end
      end else if (count_t'(i) >= pool_size) begin
        r.status = STATUS_RANGE;
      end else begin
        links[i] = head;
        head     = {1'b0, i};
        if (free_blocks < pool_size) free_blocks++;
      end
      r.count = free_blocks;
      due.push_back(r);
      return r;
    endfunction

    function void check_result(status_t s, index_t g, offset_t o, count_t c);
      alloc_result_t e;
      if (due.size() == 0) begin
        $error("result with no request outstanding: status %0d index %0d", s, g);
        errors++;
        return;
      end
      e = due.pop_front();
      if (s !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, s);
        errors++;
      end
      if (g !== e.granted) begin
        $error("granted_index: expected %0d, actual %0d", e.granted, g);
        errors++;
      end
      if (o !== e.offset) begin
        $error("byte_offset: expected %0d, actual %0d", e.offset, o);
        errors++;
      end
      if (c !== e.count) begin
        $error("free_count: expected %0d, actual %0d", e.count, c);
        errors++;
      end
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  logic       clk         = 1'b0;
  logic       rst         = 1'b1;
  logic       cfg_write   = 1'b0;
  cfg_index_t cfg_index   = CFG_BLOCK_COUNT;
  bytes_t     cfg_data    = '0;
  logic       in_valid    = 1'b0;
  logic       in_stall;
  op_t        op          = OP_ALLOC;
  index_t     block_index = '0;
  logic       out_valid;
  logic       out_stall   = 1'b0;
  status_t    status;
  index_t     granted_index;
  offset_t    byte_offset;
  count_t     free_count;

  pool_scoreboard sb;
  index_t         held[$];
  bit             tx_quiet  = 1'b0;
  logic           rx_quiet  = 1'b0;
  int             hold_reqs = 0;
  int             hold_done = 0;
  int             hold_left = 0;
  int             rx_wait   = 0;
  int             cycle_count;

  fixed_block_free_list_allocator #(
    .MAX_BLOCKS (POOL_MAX),
    .ALIGN_BYTES(ALIGN)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .block_index  (block_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .granted_index(granted_index),
    .byte_offset  (byte_offset),
    .free_count   (free_count)
  );

  always #6 clk = ~clk;

  // Result side: random stall after each result, plus an occasional long hold.
  always @(posedge clk) begin
    int w;
    if (rst) begin
      out_stall <= 1'b0;
      rx_wait   <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= (hold_left > 1);
    end else if (hold_reqs != hold_done) begin
      hold_done <= hold_done + 1;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait   <= rx_wait - 1;
      out_stall <= (rx_wait > 1);
    end else if (out_valid && !out_stall) begin
      w = rx_quiet ? 0 : $urandom_range(0, 11);
      rx_wait   <= w;
      out_stall <= (w != 0);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && !out_stall)
      sb.check_result(status, granted_index, byte_offset, free_count);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic issue(input op_t o, input index_t i);
    int            gap;
    int            k;
    alloc_result_t r;
    gap = tx_quiet ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    op          <= o;
    block_index <= i;
    do @(posedge clk); while (in_stall);
    r = sb.note_request(o, i);
    if (o == OP_ALLOC && r.status == STATUS_OK) begin
      held.push_back(r.granted);
    end else if (o == OP_FREE && r.status == STATUS_OK) begin
      for (k = 0; k < held.size(); k++)
        if (held[k] == i) begin
          held.delete(k);
          break;
        end
    end
  endtask

  // Drop valid, wait for every result, then let the pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t r, input bytes_t v);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.configure(r, v);
  endtask

  // The count write goes last since it starts a chain rebuild.
  task automatic set_pool(input bytes_t cnt, input bytes_t bts);
    drain();
    write_reg(CFG_BLOCK_BYTES, bts);
    write_reg(CFG_BLOCK_COUNT, cnt);
    held.delete();
  endtask

  task automatic run_traffic(input int n, input int alloc_pct);
    int r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (held.size() == 0 || r < alloc_pct)
        issue(OP_ALLOC, index_t'($urandom_range(0, 255)));
      else if (r < alloc_pct + (100 - alloc_pct) * 4 / 5)
        issue(OP_FREE, held[$urandom_range(0, held.size() - 1)]);
      else
        issue(OP_FREE, index_t'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    bytes_t cnt;
    bytes_t bts;
    int     pct;
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset pool: in-order grants, double free of a block, top index.
    issue(OP_ALLOC, 8'hFF);
    issue(OP_ALLOC, 8'h00);
    issue(OP_FREE, 8'd0);
    issue(OP_FREE, 8'd1);
    issue(OP_FREE, 8'd1);
    issue(OP_ALLOC, 8'h55);
    issue(OP_FREE, 8'd255);
    issue(OP_ALLOC, 8'hAA);

    // Count of zero means one block; zero size gives zero offsets.
    set_pool(13'd0, 13'd0);
    issue(OP_ALLOC, 8'd0);
    issue(OP_ALLOC, 8'd0);
    issue(OP_FREE, 8'd1);
    issue(OP_FREE, 8'd255);
    issue(OP_FREE, 8'd0);
    issue(OP_FREE, 8'd0);
    issue(OP_ALLOC, 8'd0);
    issue(OP_ALLOC, 8'd0);

    // Count above the maximum clamps; largest size wraps the offset.
    set_pool(13'h1FFF, 13'h1FFF);
    issue(OP_FREE, 8'd255);
    issue(OP_ALLOC, 8'd0);
    issue(OP_ALLOC, 8'd0);
    issue(OP_ALLOC, 8'd0);
    issue(OP_FREE, 8'd128);

    for (int p = 0; p < 8; p++) begin
      tx_quiet = 1'b0;
      rx_quiet <= 1'b0;
      case (p)
        0: begin cnt = 13'd4;      bts = bytes_t'($urandom_range(1, 64)); pct = 60; end
        1: begin cnt = 13'd300;    bts = 13'd4096;                        pct = 70; end
        2: begin cnt = 13'h1006;   bts = bytes_t'($urandom_range(0, 8191)); pct = 55; end
        3: begin cnt = 13'd2;      bts = 13'd1;                           pct = 50; end
        4: begin
          cnt = bytes_t'($urandom_range(1, 256));
          bts = bytes_t'($urandom_range(0, 8191));
          pct = 60;
        end
        5: begin cnt = 13'd200;    bts = 13'd8191;                        pct = 65; end
        6: begin
          cnt = bytes_t'($urandom_range(1, 16));
          bts = bytes_t'($urandom_range(0, 8191));
          pct = 55;
        end
        default: begin cnt = 13'd256; bts = 13'd4095; pct = 50; end
      endcase
      set_pool(cnt, bts);
      if (p == 1) begin
        // Hold the result side while requests keep coming, so the block backs up.
        tx_quiet = 1'b1;
        hold_reqs <= hold_reqs + 1;
      end
      if (p == 4) begin
        tx_quiet = 1'b1;
        rx_quiet <= 1'b1;
      end
      run_traffic(56, pct);
    end

    drain();
    repeat (16) @(posedge clk);
    if (sb.errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
